FILE: rtl/deadline_aware_ecn_window_penalty_defines.svh
// Assertion macros
`ifndef DEADLINE_AWARE_ECN_WINDOW_PENALTY_DEFINES_SVH
`define DEADLINE_AWARE_ECN_WINDOW_PENALTY_DEFINES_SVH

`ifndef SYNTH
`define DAWP_ASSERT_SAME(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
`define DAWP_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define DAWP_ASSERT_SAME(lbl, clk, rstn, pre, post)
`define DAWP_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

FILE: rtl/dawp_pkg.sv
package dawp_pkg;

    localparam logic [16:0] QONE       = 17'd65536;
    localparam logic [15:0] IMM_MAX    = 16'd65535;
    localparam logic [15:0] SEG_RESET  = 16'd1448;
    localparam logic [16:0] GAIN_RESET = 17'd4096;
    localparam logic [13:0] IMM_SCALE  = 14'd15625;  // 1024000000 = 15625 << 16
    localparam int          QUEUE_DEPTH_DEF = 2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_WEIGHT  = 1'd1;

    localparam int DVD_W = 64;
    localparam int DVS_W = 34;

    typedef struct packed {
        logic        mode;
        logic [15:0] segments_acked;
        logic        echo_marked;
        logic [31:0] ack_seq;
        logic [31:0] next_window_end;
        logic [31:0] cwnd_bytes;
        logic [31:0] flow_total_bytes;
        logic [31:0] time_left_us;
        logic [31:0] inflight_bytes;
        logic        in_recovery;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/deadline_aware_ecn_window_penalty.sv
// A query (S_QMUL, S_QCMP, S_OUT) or an ack that keeps the window open (S_BYTES, S_ACC, S_OUT)
// takes a short path; an ack that closes a window adds up to three 64-step divides plus bit-serial power.
// One item is worked at a time, while the front queue accepts new items; the shared divider and the
// 16-step square root of the power sequencer are used only by closing acks.
// Reset: aresetn synchronous active low; all totals, alpha and penalty clear to zero,
// segment_size to 1448, gain_weight to 4096, queue and output emptied.
`include "deadline_aware_ecn_window_penalty_defines.svh"
module deadline_aware_ecn_window_penalty import dawp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [15:0]          s_segments_acked,
    input  logic                 s_echo_marked,
    input  logic [31:0]          s_ack_seq,
    input  logic [31:0]          s_next_window_end,
    input  logic [31:0]          s_cwnd_bytes,
    input  logic [31:0]          s_flow_total_bytes,
    input  logic [31:0]          s_time_left_us,
    input  logic [31:0]          s_inflight_bytes,
    input  logic                 s_in_recovery,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_new_threshold,
    output logic [16:0]          m_alpha_now,
    output logic [16:0]          m_penalty_now,
    output logic                 m_window_closed
);
    item_t    in_item, q_item;
    logic     q_valid, q_ready;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign in_item.mode             = s_mode;
    assign in_item.segments_acked   = s_segments_acked;
    assign in_item.echo_marked      = s_echo_marked;
    assign in_item.ack_seq          = s_ack_seq;
    assign in_item.next_window_end  = s_next_window_end;
    assign in_item.cwnd_bytes       = s_cwnd_bytes;
    assign in_item.flow_total_bytes = s_flow_total_bytes;
    assign in_item.time_left_us     = s_time_left_us;
    assign in_item.inflight_bytes   = s_inflight_bytes;
    assign in_item.in_recovery      = s_in_recovery;

    dawp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    dawp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    dawp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .div_req         (div_req),
        .div_rsp         (div_rsp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_threshold (m_new_threshold),
        .m_alpha_now     (m_alpha_now),
        .m_penalty_now   (m_penalty_now),
        .m_window_closed (m_window_closed)
    );

    `DAWP_ASSERT_SAME(a_alpha_bound, aclk, aresetn, m_valid, m_alpha_now <= QONE)
    `DAWP_ASSERT_SAME(a_pen_bound, aclk, aresetn, m_valid, m_penalty_now <= QONE)
    `DAWP_ASSERT_SAME(a_close_thr, aclk, aresetn, m_valid && m_window_closed, m_new_threshold == '0)
    `DAWP_ASSERT_NEXT(a_div_quiet, aclk, aresetn, div_req.start, !div_rsp.done)

endmodule

FILE: rtl/dawp_front.sv
module dawp_front import dawp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  q_valid,
    input  logic  q_ready,
    output item_t q_item
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    item_t         buf_reg [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          push, pop;

    assign in_ready = (cnt_reg != FULL);
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = buf_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == LAST) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == LAST) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/dawp_div.sv
module dawp_div import dawp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg, done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/dawp_back.sv
module dawp_back import dawp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0]          cfg_wdata,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  item_t                q_item,
    output div_req_t             div_req,
    input  div_rsp_t             div_rsp,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_new_threshold,
    output logic [16:0]          m_alpha_now,
    output logic [16:0]          m_penalty_now,
    output logic                 m_window_closed
);
    typedef enum logic [4:0] {
        S_IDLE, S_QMUL, S_QCMP, S_BYTES, S_ACC, S_FRAC, S_AM1, S_AM2, S_ASUM,
        S_IMM0, S_IMM1, S_IMM2, S_IMM3, S_POW0, S_PINT, S_PSQ, S_SQS, S_SQI,
        S_FMUL, S_PDONE, S_OUT
    } state_t;

    state_t      state_reg;
    item_t       it_reg;
    logic [15:0] seg_reg;
    logic [16:0] gain_reg;
    logic [31:0] acked_reg, marked_reg, wend_reg, sent_reg;
    logic [16:0] alpha_reg, pen_reg;
    logic [31:0] bytes_reg, rem_reg, thr_reg;
    logic        closed_reg;
    logic [49:0] qprod_reg;
    logic [16:0] frac_reg;
    logic [33:0] m1_reg, m2_reg;
    logic [45:0] num_reg;
    logic [15:0] imm_reg;
    logic [16:0] r_reg, p_reg, s_reg;
    logic [7:0]  ip_reg, fp_reg;
    logic [2:0]  k_reg;
    logic [31:0] sx_reg, sres_reg, sbit_reg;
    logic        start_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic        mv_reg;
    logic [31:0] o_thr_reg;
    logic [16:0] o_alpha_reg, o_pen_reg;
    logic        o_closed_reg;

    logic [31:0] acked_sum, marked_sum, sent_sum, seq_diff, rem_c, half, qv, two;
    logic [16:0] g_clip;
    logic [31:0] strial;
    logic [34:0] acc;
    logic [33:0] rp_prod, pp_prod, rs_prod;

    assign acked_sum  = acked_reg + bytes_reg;
    assign marked_sum = it_reg.echo_marked ? marked_reg + bytes_reg : marked_reg;
    assign sent_sum   = sent_reg + bytes_reg;
    assign seq_diff   = it_reg.ack_seq - wend_reg;
    assign rem_c      = (it_reg.flow_total_bytes > sent_sum) ?
                        it_reg.flow_total_bytes - sent_sum : 32'd0;
    assign g_clip     = (gain_reg > QONE) ? QONE : gain_reg;
    assign half       = {1'b0, it_reg.inflight_bytes[31:1]};
    assign qv         = qprod_reg[48:17];
    assign two        = {15'd0, seg_reg, 1'b0};
    assign strial     = sres_reg + sbit_reg;
    assign acc        = {1'b0, m1_reg} + {1'b0, m2_reg};
    assign rp_prod    = r_reg * p_reg;
    assign pp_prod    = p_reg * p_reg;
    assign rs_prod    = r_reg * sres_reg[16:0];

    assign q_ready         = (state_reg == S_IDLE);
    assign div_req.start    = start_reg;
    assign div_req.dividend = dvd_reg;
    assign div_req.divisor  = dvs_reg;
    assign m_valid         = mv_reg;
    assign m_new_threshold = o_thr_reg;
    assign m_alpha_now     = o_alpha_reg;
    assign m_penalty_now   = o_pen_reg;
    assign m_window_closed = o_closed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            seg_reg    <= SEG_RESET;
            gain_reg   <= GAIN_RESET;
            acked_reg  <= '0;
            marked_reg <= '0;
            wend_reg   <= '0;
            sent_reg   <= '0;
            alpha_reg  <= '0;
            pen_reg    <= '0;
            start_reg  <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SEGMENT_SIZE: seg_reg  <= cfg_wdata[15:0];
                    CFG_GAIN_WEIGHT:  gain_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        it_reg    <= q_item;
                        state_reg <= q_item.mode ? S_QMUL : S_BYTES;
                    end
                end
                S_QMUL: begin
                    qprod_reg <= it_reg.cwnd_bytes * (18'd131072 - {1'b0, pen_reg});
                    state_reg <= S_QCMP;
                end
                S_QCMP: begin
                    if (it_reg.in_recovery) begin
                        thr_reg <= (two > half) ? two : half;
                    end else begin
                        thr_reg <= (qv > half) ? qv : half;
                    end
                    closed_reg <= 1'b0;
                    state_reg  <= S_OUT;
                end
                S_BYTES: begin
                    bytes_reg <= seg_reg * it_reg.segments_acked;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    thr_reg  <= '0;
                    sent_reg <= sent_sum;
                    rem_reg  <= rem_c;
                    if (!seq_diff[31]) begin
                        closed_reg <= 1'b1;
                        wend_reg   <= it_reg.next_window_end;
                        acked_reg  <= '0;
                        marked_reg <= '0;
                        if (acked_sum == '0) begin
                            frac_reg  <= '0;
                            state_reg <= S_AM1;
                        end else begin
                            start_reg <= 1'b1;
                            dvd_reg   <= {16'd0, marked_sum, 16'd0};
                            dvs_reg   <= {2'd0, acked_sum};
                            state_reg <= S_FRAC;
                        end
                    end else begin
                        closed_reg <= 1'b0;
                        acked_reg  <= acked_sum;
                        marked_reg <= marked_sum;
                        state_reg  <= S_OUT;
                    end
                end
                S_FRAC: begin
                    if (div_rsp.done) begin
                        frac_reg  <= (div_rsp.quotient > 64'(QONE)) ? QONE :
                                     div_rsp.quotient[16:0];
                        state_reg <= S_AM1;
                    end
                end
                S_AM1: begin
                    m1_reg    <= (QONE - g_clip) * alpha_reg;
                    state_reg <= S_AM2;
                end
                S_AM2: begin
                    m2_reg    <= g_clip * frac_reg;
                    state_reg <= S_ASUM;
                end
                S_ASUM: begin
                    alpha_reg <= acc[32:16];
                    state_reg <= S_IMM0;
                end
                S_IMM0: begin
                    if (rem_reg == '0) begin
                        imm_reg   <= '0;
                        state_reg <= S_POW0;
                    end else if (it_reg.cwnd_bytes == '0 || it_reg.time_left_us == '0) begin
                        imm_reg   <= IMM_MAX;
                        state_reg <= S_POW0;
                    end else begin
                        num_reg   <= rem_reg * IMM_SCALE;
                        state_reg <= S_IMM1;
                    end
                end
                S_IMM1: begin
                    start_reg <= 1'b1;
                    dvd_reg   <= {2'd0, num_reg, 16'd0};
                    dvs_reg   <= {2'd0, it_reg.cwnd_bytes} + {1'b0, it_reg.cwnd_bytes, 1'b0};
                    state_reg <= S_IMM2;
                end
                S_IMM2: begin
                    if (div_rsp.done) begin
                        start_reg <= 1'b1;
                        dvd_reg   <= div_rsp.quotient;
                        dvs_reg   <= {2'd0, it_reg.time_left_us};
                        state_reg <= S_IMM3;
                    end
                end
                S_IMM3: begin
                    if (div_rsp.done) begin
                        imm_reg   <= (div_rsp.quotient > 64'(IMM_MAX)) ? IMM_MAX :
                                     div_rsp.quotient[15:0];
                        state_reg <= S_POW0;
                    end
                end
                S_POW0: begin
                    if (imm_reg == '0 || alpha_reg >= QONE) begin
                        pen_reg   <= QONE;
                        state_reg <= S_OUT;
                    end else if (alpha_reg == '0) begin
                        pen_reg   <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        r_reg     <= QONE;
                        p_reg     <= alpha_reg;
                        s_reg     <= alpha_reg;
                        ip_reg    <= imm_reg[15:8];
                        fp_reg    <= imm_reg[7:0];
                        k_reg     <= 3'd7;
                        state_reg <= S_PINT;
                    end
                end
                S_PINT: begin
                    if (ip_reg == '0) begin
                        state_reg <= S_SQS;
                    end else begin
                        if (ip_reg[0]) begin
                            r_reg <= rp_prod[32:16];
                        end
                        state_reg <= S_PSQ;
                    end
                end
                S_PSQ: begin
                    p_reg     <= pp_prod[32:16];
                    ip_reg    <= {1'b0, ip_reg[7:1]};
                    state_reg <= S_PINT;
                end
                S_SQS: begin
                    sx_reg    <= {s_reg[15:0], 16'd0};
                    sres_reg  <= '0;
                    sbit_reg  <= 32'h4000_0000;
                    state_reg <= S_SQI;
                end
                S_SQI: begin
                    if (sx_reg >= strial) begin
                        sx_reg   <= sx_reg - strial;
                        sres_reg <= {1'b0, sres_reg[31:1]} + sbit_reg;
                    end else begin
                        sres_reg <= {1'b0, sres_reg[31:1]};
                    end
                    sbit_reg <= {2'd0, sbit_reg[31:2]};
                    if (sbit_reg == 32'd1) begin
                        state_reg <= S_FMUL;
                    end
                end
                S_FMUL: begin
                    s_reg <= sres_reg[16:0];
                    if (fp_reg[k_reg]) begin
                        r_reg <= rs_prod[32:16];
                    end
                    if (k_reg == '0) begin
                        state_reg <= S_PDONE;
                    end else begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= S_SQS;
                    end
                end
                S_PDONE: begin
                    pen_reg   <= r_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!mv_reg || m_ready) begin
                        mv_reg       <= 1'b1;
                        o_thr_reg    <= thr_reg;
                        o_alpha_reg  <= alpha_reg;
                        o_pen_reg    <= pen_reg;
                        o_closed_reg <= closed_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: test/deadline_aware_ecn_window_penalty_test.sv
module deadline_aware_ecn_window_penalty_test import dawp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] thr;
        logic [16:0] alpha;
        logic [16:0] penalty;
        logic        closed;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SEGMENT_SIZE;
    logic [16:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [31:0] m_new_threshold;
    logic [16:0] m_alpha_now;
    logic [16:0] m_penalty_now;
    logic m_window_closed;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    deadline_aware_ecn_window_penalty u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(s_item.mode), .s_segments_acked(s_item.segments_acked),
        .s_echo_marked(s_item.echo_marked), .s_ack_seq(s_item.ack_seq),
        .s_next_window_end(s_item.next_window_end), .s_cwnd_bytes(s_item.cwnd_bytes),
        .s_flow_total_bytes(s_item.flow_total_bytes),
        .s_time_left_us(s_item.time_left_us), .s_inflight_bytes(s_item.inflight_bytes),
        .s_in_recovery(s_item.in_recovery),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_threshold(m_new_threshold), .m_alpha_now(m_alpha_now),
        .m_penalty_now(m_penalty_now), .m_window_closed(m_window_closed)
    );

    // predictor state
    logic [15:0] seg_size = SEG_RESET;
    logic [16:0] gain = GAIN_RESET;
    logic [31:0] win_acked, win_marked, win_end, sent_bytes;
    logic [16:0] alpha_q, penalty_q;

    item_t pending_items[$];
    verdict_t expected_verdicts[$];
    int errors = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;

    function automatic logic [31:0] q16_mul(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return 32'(p >> 16);
    endfunction

    function automatic logic [31:0] int_sqrt(logic [63:0] x);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] alpha_power(logic [31:0] a, logic [15:0] imm);
        logic [31:0] r, p, s;
        logic [7:0] ip, fp;
        r = 32'(QONE);
        p = a;
        s = a;
        if (imm == 0) return 32'(QONE);
        if (a == 0) return 0;
        if (a >= 32'(QONE)) return 32'(QONE);
        ip = imm[15:8];
        fp = imm[7:0];
        while (ip != 0) begin
            if (ip[0]) r = q16_mul(r, p);
            p = q16_mul(p, p);
            ip >>= 1;
        end
        for (int k = 7; k >= 0; k--) begin
            s = int_sqrt(64'(s) << 16);
            if (fp[k]) r = q16_mul(r, s);
        end
        return r;
    endfunction

    function automatic logic [15:0] imminence_of(logic [31:0] rem, logic [31:0] cwnd,
                                                 logic [31:0] t_us);
        logic [127:0] q;
        if (rem == 0) return 0;
        if (cwnd == 0 || t_us == 0) return IMM_MAX;
        q = (128'(rem) * 128'd1024000000) / (128'd3 * 128'(cwnd));
        q = q / 128'(t_us);
        return (q > 128'(IMM_MAX)) ? IMM_MAX : q[15:0];
    endfunction

    function automatic verdict_t predict_penalty(item_t it);
        verdict_t v;
        logic [31:0] half, two, bytes, frac, g, rem;
        logic [63:0] f, acc, fq;
        v.thr = 0;
        v.closed = 0;
        if (it.mode) begin
            half = it.inflight_bytes / 2;
            if (it.in_recovery) begin
                two = 32'(2 * 32'(seg_size));
                v.thr = two > half ? two : half;
            end else begin
                f = 64'(it.cwnd_bytes) * 64'(32'd131072 - 32'(penalty_q));
                two = 32'(f >> 17);
                v.thr = two > half ? two : half;
            end
        end else begin
            bytes = 32'(it.segments_acked) * 32'(seg_size);
            win_acked += bytes;
            sent_bytes += bytes;
            if (it.echo_marked) win_marked += bytes;
            if (((it.ack_seq - win_end) & 32'h8000_0000) == 0) begin
                v.closed = 1;
                frac = 0;
                win_end = it.next_window_end;
                if (win_acked != 0) begin
                    fq = (64'(win_marked) << 16) / 64'(win_acked);
                    frac = fq > 64'(QONE) ? 32'(QONE) : fq[31:0];
                end
                g = gain > QONE ? 32'(QONE) : 32'(gain);
                acc = 64'(32'(QONE) - g) * 64'(alpha_q) + 64'(g) * 64'(frac);
                alpha_q = 17'(acc >> 16);
                win_acked = 0;
                win_marked = 0;
                rem = it.flow_total_bytes > sent_bytes ? it.flow_total_bytes - sent_bytes : 0;
                penalty_q = 17'(alpha_power(32'(alpha_q),
                                imminence_of(rem, it.cwnd_bytes, it.time_left_us)));
            end
        end
        v.alpha = alpha_q;
        v.penalty = penalty_q;
        return v;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_verdicts.push_back(predict_penalty(s_item));
                void'(pending_items.pop_front());
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
                if (send_gap == 0 && pending_items.size() > 0) begin
                    s_item <= pending_items[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    s_item <= pending_items[0];
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge aclk) begin
        verdict_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected beat");
                    errors++;
                end else begin
                    e = expected_verdicts.pop_front();
                    if (m_new_threshold !== e.thr) begin
                        $error("new_threshold exp %0d got %0d", e.thr, m_new_threshold);
                        errors++;
                    end
                    if (m_alpha_now !== e.alpha) begin
                        $error("alpha_now exp %0d got %0d", e.alpha, m_alpha_now);
                        errors++;
                    end
                    if (m_penalty_now !== e.penalty) begin
                        $error("penalty_now exp %0d got %0d", e.penalty, m_penalty_now);
                        errors++;
                    end
                    if (m_window_closed !== e.closed) begin
                        $error("window_closed exp %0d got %0d", e.closed, m_window_closed);
                        errors++;
                    end
                end
                recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    logic [31:0] seq_base = 0;

    // tracks window ends queued so far so ack streams mostly close windows in order
    function automatic logic [31:0] win_end_guess();
        return seq_base;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.mode = $urandom_range(0, 3) == 0;
        it.segments_acked = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
        it.echo_marked = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
            it.ack_seq = $urandom;
            it.next_window_end = $urandom;
        end else begin
            it.ack_seq = win_end_guess() + ($urandom_range(0, 2) == 0 ? -32'd5 : 32'd3);
            it.next_window_end = it.ack_seq + $urandom_range(1, 200000);
        end
        case ($urandom_range(0, 4))
            0: it.cwnd_bytes = 0;
            1: it.cwnd_bytes = $urandom;
            default: it.cwnd_bytes = $urandom_range(1000, 2000000);
        endcase
        it.flow_total_bytes = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 50000000);
        case ($urandom_range(0, 4))
            0: it.time_left_us = 0;
            1: it.time_left_us = $urandom;
            default: it.time_left_us = $urandom_range(1, 100000);
        endcase
        it.inflight_bytes = $urandom;
        it.in_recovery = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic queue_item(item_t it);
        pending_items.push_back(it);
        if (!it.mode && (((it.ack_seq - seq_base) & 32'h8000_0000) == 0))
            seq_base = it.next_window_end;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_verdicts.size() > 0)
            @(posedge aclk);
        repeat (500) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SEGMENT_SIZE) seg_size = val[15:0];
        else gain = val;
    endtask

    function automatic item_t make_item(bit md, logic [15:0] segs, bit echo, logic [31:0] ack,
                                        logic [31:0] nxt, logic [31:0] cwnd, logic [31:0] tot,
                                        logic [31:0] t_us, logic [31:0] infl, bit rec);
        item_t it;
        it.mode = md; it.segments_acked = segs; it.echo_marked = echo;
        it.ack_seq = ack; it.next_window_end = nxt; it.cwnd_bytes = cwnd;
        it.flow_total_bytes = tot; it.time_left_us = t_us; it.inflight_bytes = infl;
        it.in_recovery = rec;
        return it;
    endfunction

    initial begin
        win_acked = 0; win_marked = 0; win_end = 0; sent_bytes = 0;
        alpha_q = 0; penalty_q = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        queue_item(make_item(1, 0, 0, 0, 0, 100000, 0, 0, '1, 1));
        queue_item(make_item(1, 0, 0, 0, 0, '1, 0, 0, 0, 0));
        queue_item(make_item(0, 0, 0, 0, 1000, 0, 0, 0, 0, 0));
        queue_item(make_item(0, 10, 1, 500, 2000, 50000, 0, 1000, 0, 0));
        queue_item(make_item(0, 10, 1, 1000, 5000, 50000, 10000000, 1000, 0, 0));
        queue_item(make_item(0, 16'hFFFF, 1, 5000, 9000, 0, '1, 10, 0, 0));
        queue_item(make_item(0, 5, 0, 9000, 20000, 30000, '1, 0, 0, 0));
        queue_item(make_item(0, 5, 1, 9000 + 32'h8000_0000, 30000, '1, '1, '1, 0, 0));
        queue_item(make_item(0, 1, 1, 30000, 40000, 1, '1, 1, 0, 0));
        queue_item(make_item(1, 0, 1, 0, 0, '1, '1, '1, 6, 0));
        queue_item(make_item(1, 16'hFFFF, 1, '1, '1, 1, 0, 0, 7, 1));
        for (int i = 0; i < 6; i++)
            queue_item(make_item(0, 20, 1, seq_base, seq_base + 1000, 40000, '1, 200, 0, 0));
        queue_item(make_item(1, 0, 0, 0, 0, '1, 0, 0, 0, 0));
        drain();

        write_reg(CFG_SEGMENT_SIZE, 17'd65535);
        write_reg(CFG_GAIN_WEIGHT, 17'd65536);
        for (int i = 0; i < 300; i++) queue_item(rand_item());
        drain();

        write_reg(CFG_SEGMENT_SIZE, 17'd1);
        write_reg(CFG_GAIN_WEIGHT, 17'd0);
        for (int i = 0; i < 150; i++) queue_item(rand_item());
        drain();

        write_reg(CFG_SEGMENT_SIZE, 17'd1500);
        write_reg(CFG_GAIN_WEIGHT, 17'h1FFFF);
        for (int i = 0; i < 200; i++) queue_item(rand_item());
        drain();

        write_reg(CFG_SEGMENT_SIZE, 17'($urandom_range(1, 65535)));
        write_reg(CFG_GAIN_WEIGHT, 17'($urandom_range(0, 65536)));
        hold_off = 1'b1;
        for (int i = 0; i < 350; i++) queue_item(rand_item());
        repeat (3000) @(posedge aclk);
        hold_off = 1'b0;
        drain();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        wait (cycles >= 1500000);
        $display("TB_ERROR");
        $finish;
    end
endmodule
